/* rtl/apq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apq_pkg: shared types and constants of the array priority queue
// Sizes, request and status codes, beat payloads and the control bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package apq_pkg;

    // Storage sizes.
    localparam int DEPTH     = 16;
    localparam int TAG_BITS  = 16;
    localparam int PRIO_BITS = 8;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // Fixed field widths of the beats and of the capacity register.
    localparam int REQ_BITS    = 3;
    localparam int STATUS_BITS = 2;
    localparam int POS_BITS    = 4;
    localparam int CAP_BITS    = 5;
    localparam int CMP_BITS    = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    // Request codes.
    localparam logic [REQ_BITS-1:0] REQ_APPEND  = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_INSERT  = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_EXTRACT = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_FIND    = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_COUNT   = 3'd4;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

    // Configuration register byte addresses.
    localparam logic [1:0] ADDR_CAPACITY = 2'd0;

    // Input beat.
    typedef struct packed {
        logic [REQ_BITS-1:0]  req_type;
        logic [TAG_BITS-1:0]  item_tag;
        logic [PRIO_BITS-1:0] priority_req;
    } apq_req_t;

    // Result beat.
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [TAG_BITS-1:0]    out_tag;
        logic [PRIO_BITS-1:0]   out_priority;
        logic [POS_BITS-1:0]    position;
        logic [POS_BITS-1:0]    ahead_count;
    } apq_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic set_full;
        logic set_empty;
        logic do_tail;
        logic do_scan;
        logic commit;
        logic out_load;
    } apq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_BITS-1:0] req;
        logic                full;
        logic                empty;
        logic                tail_ge;
        logic                hit;
        logic                last;
        logic                out_free;
    } apq_stat_t;

endpackage
`default_nettype wire

/* rtl/apq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apq_ctrl: request sequencer of the array priority queue
// Steps each request through decode, tail check, linear scan, list update
// and result hand-off, driving the datapath by commands.
// ----------------------------------------------------------------------------
module apq_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire apq_pkg::apq_stat_t stat,
    output apq_pkg::apq_cmd_t       cmd
);
    import apq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_TAIL   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       is_insert;
    logic       is_lookup;

    assign is_insert = (stat.req == REQ_APPEND) || (stat.req == REQ_INSERT);
    assign is_lookup = (stat.req == REQ_FIND) || (stat.req == REQ_COUNT);
    assign s_ready   = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_START;
                end
            end
            S_START: begin
                if (is_insert) begin
                    if (stat.full) begin
                        cmd.set_full = 1'b1;
                        state_next   = S_OUT;
                    end else if (stat.req == REQ_APPEND || stat.empty) begin
                        state_next = S_COMMIT;
                    end else begin
                        state_next = S_TAIL;
                    end
                end else if (stat.req == REQ_EXTRACT) begin
                    if (stat.empty) begin
                        cmd.set_empty = 1'b1;
                        state_next    = S_OUT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end else if (is_lookup) begin
                    state_next = stat.empty ? S_OUT : S_SCAN;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_TAIL: begin
                cmd.do_tail = 1'b1;
                state_next  = stat.tail_ge ? S_COMMIT : S_SCAN;
            end
            S_SCAN: begin
                cmd.do_scan = 1'b1;
                if (stat.hit || stat.last) begin
                    state_next = is_lookup ? S_OUT : S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A request is only taken in the idle state and always moves to decode.
    a_accept_to_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_START))
        else $error("accepted beat did not start decoding");

    // The list is only changed for requests that modify it.
    a_commit_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (is_insert || stat.req == REQ_EXTRACT))
        else $error("list update for a lookup request");

    // A lookup never reaches the update step.
    a_lookup_no_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && is_lookup) |=> (state_reg != S_COMMIT))
        else $error("lookup scan went to list update");

endmodule
`default_nettype wire

/* rtl/apq_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apq_datapath: entry storage, scan unit and result register
// Holds the entry rows and fill level, scans one row per cycle through a
// single read port, shifts rows in one step on update, and keeps the
// result beat in an output register.
// ----------------------------------------------------------------------------
module apq_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire apq_pkg::apq_cmd_t                cmd,
    output apq_pkg::apq_stat_t                    stat,
    input  wire apq_pkg::apq_req_t                s_data,
    input  wire logic [apq_pkg::CAP_BITS-1:0]     capacity,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output apq_pkg::apq_rsp_t                     m_data
);
    import apq_pkg::*;

    // Entry rows.
    logic [PRIO_BITS-1:0] prio_mem [DEPTH];
    logic [TAG_BITS-1:0]  tag_mem  [DEPTH];
    logic [PRIO_BITS-1:0] prio_prev [DEPTH];
    logic [TAG_BITS-1:0]  tag_prev  [DEPTH];
    logic [PRIO_BITS-1:0] prio_succ [DEPTH];
    logic [TAG_BITS-1:0]  tag_succ  [DEPTH];

    logic [CNT_BITS-1:0]    fill_reg;
    logic [REQ_BITS-1:0]    req_reg;
    logic [TAG_BITS-1:0]    new_tag_reg;
    logic [PRIO_BITS-1:0]   key_reg;
    logic [CNT_BITS-1:0]    idx_reg;
    logic [CNT_BITS-1:0]    pos_reg;
    logic [IDX_BITS-1:0]    best_idx_reg;
    logic [PRIO_BITS-1:0]   best_prio_reg;
    logic [TAG_BITS-1:0]    best_tag_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic                   m_valid_reg;
    apq_rsp_t               rsp_reg;
    apq_rsp_t               rsp_next;

    logic [IDX_BITS-1:0]  rd_addr;
    logic [PRIO_BITS-1:0] rd_prio;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [CNT_BITS-1:0]  fill_m1;
    logic                 is_insert;
    logic                 find_hit;
    logic                 ins_hit;
    logic                 ok;

    // Neighbor rows for the one-step shifts.
    for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
        if (g == 0) begin : g_first
            assign prio_prev[g] = '0;
            assign tag_prev[g]  = '0;
        end else begin : g_mid
            assign prio_prev[g] = prio_mem[g-1];
            assign tag_prev[g]  = tag_mem[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign prio_succ[g] = '0;
            assign tag_succ[g]  = '0;
        end else begin : g_body
            assign prio_succ[g] = prio_mem[g+1];
            assign tag_succ[g]  = tag_mem[g+1];
        end
    end

    // Single read port: tail row during the tail check, else the scan row.
    assign fill_m1 = fill_reg - CNT_BITS'(1);
    assign rd_addr = cmd.do_tail ? fill_m1[IDX_BITS-1:0] : idx_reg[IDX_BITS-1:0];
    assign rd_prio = prio_mem[rd_addr];
    assign rd_tag  = tag_mem[rd_addr];

    assign is_insert = (req_reg == REQ_APPEND) || (req_reg == REQ_INSERT);
    assign find_hit  = (req_reg == REQ_FIND) && (rd_prio == key_reg);
    assign ins_hit   = (req_reg == REQ_INSERT) && (rd_prio >= key_reg);
    assign ok        = (status_reg == ST_OK);

    // Status toward the controller. A key at or below the head priority
    // belongs at the head, so the tail shortcut only applies above it and
    // the scan then stops on the head row.
    always_comb begin
        stat.req      = req_reg;
        stat.full     = (CMP_BITS'(fill_reg) >= CMP_BITS'(capacity))
                        || (fill_reg == CNT_BITS'(DEPTH));
        stat.empty    = (fill_reg == '0);
        stat.tail_ge  = (key_reg >= rd_prio) && (key_reg > prio_mem[0]);
        stat.hit      = find_hit || ins_hit;
        stat.last     = ((idx_reg + CNT_BITS'(1)) == fill_reg);
        stat.out_free = !m_valid_reg || m_ready;
    end

    // Request latch and scan registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg       <= s_data.req_type;
            new_tag_reg   <= s_data.item_tag;
            key_reg       <= s_data.priority_req;
            idx_reg       <= '0;
            pos_reg       <= fill_reg;
            best_idx_reg  <= '0;
            best_prio_reg <= '0;
            best_tag_reg  <= '0;
            cnt_reg       <= '0;
            status_reg    <= (s_data.req_type == REQ_FIND) ? ST_NOT_FOUND : ST_OK;
        end else begin
            if (cmd.set_full) begin
                status_reg <= ST_FULL;
            end
            if (cmd.set_empty) begin
                status_reg <= ST_EMPTY;
            end
            if (cmd.do_tail && !stat.tail_ge) begin
                pos_reg <= fill_m1;
            end
            if (cmd.do_scan) begin
                idx_reg <= idx_reg + CNT_BITS'(1);
                if (find_hit) begin
                    status_reg <= ST_OK;
                    pos_reg    <= idx_reg;
                end
                if (ins_hit) begin
                    pos_reg <= idx_reg;
                end
                if (req_reg == REQ_EXTRACT && (idx_reg == '0 || rd_prio > best_prio_reg)) begin
                    best_idx_reg  <= idx_reg[IDX_BITS-1:0];
                    best_prio_reg <= rd_prio;
                    best_tag_reg  <= rd_tag;
                end
                if (req_reg == REQ_COUNT && rd_prio >= key_reg) begin
                    cnt_reg <= cnt_reg + CNT_BITS'(1);
                end
            end
        end
    end

    // Row update: open a gap for an insert, close it after an extract.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (is_insert) begin
                    if (CNT_BITS'(i) == pos_reg) begin
                        prio_mem[i] <= key_reg;
                        tag_mem[i]  <= new_tag_reg;
                    end else if (CNT_BITS'(i) > pos_reg && CNT_BITS'(i) <= fill_reg) begin
                        prio_mem[i] <= prio_prev[i];
                        tag_mem[i]  <= tag_prev[i];
                    end
                end else if (CNT_BITS'(i) >= CNT_BITS'(best_idx_reg)
                             && (CNT_BITS'(i) + CNT_BITS'(1)) < fill_reg) begin
                    prio_mem[i] <= prio_succ[i];
                    tag_mem[i]  <= tag_succ[i];
                end
            end
        end
    end

    // Fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.commit) begin
            fill_reg <= is_insert ? fill_reg + CNT_BITS'(1) : fill_m1;
        end
    end

    // Result beat.
    always_comb begin
        rsp_next              = '0;
        rsp_next.status       = status_reg;
        if (req_reg == REQ_EXTRACT && ok) begin
            rsp_next.out_tag      = best_tag_reg;
            rsp_next.out_priority = best_prio_reg;
        end
        if (req_reg == REQ_FIND && ok) begin
            rsp_next.position = POS_BITS'(pos_reg);
        end
        if (req_reg == REQ_COUNT && cnt_reg != '0) begin
            rsp_next.ahead_count = POS_BITS'(cnt_reg - CNT_BITS'(1));
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

    // The fill level never passes the row count.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_BITS'(DEPTH))
        else $error("fill level above depth");

    // An extract removes exactly one entry.
    a_extract_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && req_reg == REQ_EXTRACT) |=> (fill_reg == $past(fill_m1)))
        else $error("extract did not lower the fill level by one");

    // A found position lies inside the list.
    a_find_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && req_reg == REQ_FIND && ok) |-> (pos_reg < fill_reg))
        else $error("find position outside the list");

    // A new result is only loaded when the output register is free.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

/* rtl/array_priority_queue_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// array_priority_queue_core: bounded priority list with linear scan
// Append, ordered insert, extract-max, find and count requests on a list
// of up to DEPTH entries, with a capacity register on an APB-style port.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Beat
//  s_        in         s_valid / s_ready       apq_req_t (request)
//  m_        out        m_valid / m_ready       apq_rsp_t (result)
//  APB       in         psel/penable, pready=1  capacity at byte address 0
//
//  A refused request, a lookup on an empty list or an unknown kind goes from
//  decode straight to the result hand-off; an append, or an insert that goes
//  to an empty list or past the tail, passes the list update first. The rest
//  scan, reading one entry per cycle through the single read port.
//  Reset empties the list and sets capacity to 16; entries are not cleared.
//  A new request is taken once the previous one has left the sequencer,
//  even while its result beat still waits for m_ready.
// ----------------------------------------------------------------------------
module array_priority_queue_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire apq_pkg::apq_req_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output apq_pkg::apq_rsp_t      m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [1:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import apq_pkg::*;

    logic [CAP_BITS-1:0] capacity_reg;
    apq_cmd_t            cmd;
    apq_stat_t           stat;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? 32'(capacity_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
            capacity_reg <= pwdata[CAP_BITS-1:0];
        end
    end

    // Sequencer.
    apq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Storage, scan and result.
    apq_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_data   (s_data),
        .capacity (capacity_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

/* tb/array_priority_queue_core_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// array_priority_queue_core_tb: self-checking bench for the priority list
// Request beats go in from a backlog through a valid/ready driver, and a
// shadow list predicts every result beat. Each result beat is checked field
// by field against the oldest prediction. The capacity register is written
// and read back between phases, and both channels stall at random.
// ----------------------------------------------------------------------------
module array_priority_queue_core_tb;
    import apq_pkg::*;

    // One queued request beat and the idle cycles that come before it.
    typedef struct {
        apq_req_t rq;
        int       gap;
    } req_slot_t;

    localparam int HOLD_CYCLES = 200;
    localparam int MAX_IDLE    = 10;
    localparam int DRAIN_WAIT  = 30;
    localparam int REQ_TOP     = (1 << REQ_BITS) - 1;

    // DUT ports.
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    apq_req_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    apq_rsp_t    m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [1:0]  paddr   = ADDR_CAPACITY;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the list and of the capacity register.
    logic [PRIO_BITS-1:0] shadow_prio [DEPTH];
    logic [TAG_BITS-1:0]  shadow_tag  [DEPTH];
    int                   shadow_fill = 0;
    int                   shadow_cap  = int'(CAP_RESET);

    // Stimulus backlog and results still owed by the block.
    req_slot_t req_backlog [$];
    req_slot_t head_slot;
    apq_rsp_t  rsp_due [$];
    apq_rsp_t  rsp_want;

    // Handshake flags set at the rising edge, used at the falling edge.
    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;

    int  n_pushed  = 0;
    int  n_done    = 0;
    int  n_err     = 0;
    bit  idle_on   = 1'b1;
    int  gap_left  = 0;
    bit  gap_armed = 1'b0;
    int  rcv_wait  = 0;
    int  hold_ask  = 0;
    int  hold_seen = 0;
    int  hold_left = 0;

    array_priority_queue_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // Applies one request to the shadow list and returns the result it owes.
    function automatic apq_rsp_t prio_list_step(input apq_req_t rq);
        apq_rsp_t r;
        int       limit;
        int       slot;
        int       best;
        int       hits;
        bit       found;
        r     = '0;
        limit = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        case (rq.req_type)
            REQ_APPEND, REQ_INSERT: begin
                if (shadow_fill >= limit) begin
                    r.status = ST_FULL;
                end else begin
                    slot = shadow_fill;
                    // Ordered insert copes with an unsorted list: head, tail,
                    // or before the first entry at or above the new priority.
                    if (rq.req_type == REQ_INSERT && shadow_fill > 0) begin
                        if (rq.priority_req <= shadow_prio[0]) begin
                            slot = 0;
                        end else if (rq.priority_req >= shadow_prio[shadow_fill-1]) begin
                            slot = shadow_fill;
                        end else begin
                            slot = shadow_fill - 1;
                            for (int i = shadow_fill - 1; i >= 0; i--) begin
                                if (shadow_prio[i] >= rq.priority_req)
                                    slot = i;
                            end
                        end
                    end
                    for (int i = shadow_fill; i > slot; i--) begin
                        shadow_prio[i] = shadow_prio[i-1];
                        shadow_tag[i]  = shadow_tag[i-1];
                    end
                    shadow_prio[slot] = rq.priority_req;
                    shadow_tag[slot]  = rq.item_tag;
                    shadow_fill++;
                end
            end
            REQ_EXTRACT: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // First maximum wins, also when all priorities are zero.
                    best = 0;
                    for (int i = 1; i < shadow_fill; i++) begin
                        if (shadow_prio[i] > shadow_prio[best])
                            best = i;
                    end
                    r.out_tag      = shadow_tag[best];
                    r.out_priority = shadow_prio[best];
                    for (int i = best + 1; i < shadow_fill; i++) begin
                        shadow_prio[i-1] = shadow_prio[i];
                        shadow_tag[i-1]  = shadow_tag[i];
                    end
                    shadow_fill--;
                end
            end
            REQ_FIND: begin
                found    = 1'b0;
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < shadow_fill; i++) begin
                    if (!found && shadow_prio[i] == rq.priority_req) begin
                        found      = 1'b1;
                        r.status   = ST_OK;
                        r.position = POS_BITS'(i);
                    end
                end
            end
            REQ_COUNT: begin
                hits = 0;
                for (int i = 0; i < shadow_fill; i++) begin
                    if (shadow_prio[i] >= rq.priority_req)
                        hits++;
                end
                r.ahead_count = POS_BITS'((hits > 0) ? hits - 1 : 0);
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // Reports the first few failures in full and counts the rest.
    task automatic note_fail(input string msg);
        if (n_err < 10)
            $display("ERROR @%0t: %s", $time, msg);
        n_err++;
    endtask

    // Queues one request beat, with a random lead-in gap while idle gaps are on.
    task automatic push_req(input logic [REQ_BITS-1:0] kind,
                            input logic [TAG_BITS-1:0] tag,
                            input logic [PRIO_BITS-1:0] prio);
        req_slot_t slot;
        slot.rq.req_type     = kind;
        slot.rq.item_tag     = tag;
        slot.rq.priority_req = prio;
        slot.gap             = idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
        req_backlog.push_back(slot);
        n_pushed++;
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cap_readback();
        logic [31:0] rd;
        apb_xfer(1'b0, '0, rd);
        if (rd[CAP_BITS-1:0] !== CAP_BITS'(shadow_cap))
            note_fail($sformatf("capacity readback: want %0d, got %0d",
                                shadow_cap, rd[CAP_BITS-1:0]));
    endtask

    task automatic set_capacity(input int cap);
        logic [31:0] unused;
        apb_xfer(1'b1, 32'(cap), unused);
        shadow_cap = cap & ((1 << CAP_BITS) - 1);
        cap_readback();
    endtask

    // Holds the sender back until every owed result beat has been checked.
    task automatic wait_idle();
        while (n_done != n_pushed)
            @(negedge aclk);
    endtask

    // Random phase: mostly inserts and extractions with repeating priorities,
    // plus find, count and unknown request kinds.
    task automatic run_phase(input int cap, input int count, input int fill_pct,
                             input bit idle, input bit stall_rx);
        logic [REQ_BITS-1:0]  kind;
        logic [PRIO_BITS-1:0] prio;
        int                   pick;
        set_capacity(cap);
        idle_on = idle;
        @(posedge aclk);
        if (stall_rx)
            hold_ask++;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < fill_pct) begin
                kind = ($urandom_range(0, 1) != 0) ? REQ_INSERT : REQ_APPEND;
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 9)
                    kind = REQ_EXTRACT;
                else if (pick < 14)
                    kind = REQ_FIND;
                else if (pick < 18)
                    kind = REQ_COUNT;
                else
                    kind = REQ_BITS'($urandom_range(int'(REQ_COUNT) + 1, REQ_TOP));
            end
            if ($urandom_range(0, 3) == 0)
                prio = PRIO_BITS'($urandom_range(0, 255));
            else
                prio = PRIO_BITS'($urandom_range(0, 5) * 51);
            push_req(kind, TAG_BITS'($urandom_range(0, 65535)), prio);
        end
        wait_idle();
    endtask

    // Request driver: presents backlog beats at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (req_backlog.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                if (!gap_armed) begin
                    gap_left  = req_backlog[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    head_slot = req_backlog.pop_front();
                    s_data    <= head_slot.rq;
                    s_valid   <= 1'b1;
                    gap_armed = 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls per beat, plus one long hold-off.
    always @(negedge aclk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (rsp_taken)
            rcv_wait = idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rcv_wait > 0) begin
            rcv_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predicts on each accepted request, checks each result beat.
    always @(posedge aclk) begin
        req_taken = 1'b0;
        rsp_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                rsp_due.push_back(prio_list_step(s_data));
                req_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                rsp_taken = 1'b1;
                if (rsp_due.size() == 0) begin
                    note_fail($sformatf("unexpected result beat %h", m_data));
                end else begin
                    rsp_want = rsp_due.pop_front();
                    if (m_data.status !== rsp_want.status ||
                        m_data.out_tag !== rsp_want.out_tag ||
                        m_data.out_priority !== rsp_want.out_priority ||
                        m_data.position !== rsp_want.position ||
                        m_data.ahead_count !== rsp_want.ahead_count)
                        note_fail($sformatf(
                            "result: want %0d/%h/%h/%0d/%0d got %0d/%h/%h/%0d/%0d",
                            rsp_want.status, rsp_want.out_tag, rsp_want.out_priority,
                            rsp_want.position, rsp_want.ahead_count,
                            m_data.status, m_data.out_tag, m_data.out_priority,
                            m_data.position, m_data.ahead_count));
                    n_done++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Test sequence.
    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        cap_readback();

        // Directed: empty list, unknown kinds, field extremes, unsorted
        // ordered inserts, zero-priority ties on extraction.
        @(posedge aclk);
        push_req(REQ_EXTRACT, '0, '0);
        push_req(REQ_FIND, '0, '0);
        push_req(REQ_COUNT, '0, '0);
        for (int k = int'(REQ_COUNT) + 1; k <= REQ_TOP; k++)
            push_req(REQ_BITS'(k), '1, '1);
        push_req(REQ_APPEND, 16'h0000, 8'h00);
        push_req(REQ_APPEND, 16'hFFFF, 8'hFF);
        push_req(REQ_INSERT, 16'h1234, 8'h80);
        push_req(REQ_APPEND, 16'hAAAA, 8'h00);
        push_req(REQ_INSERT, 16'h5555, 8'h00);
        push_req(REQ_INSERT, 16'h0F0F, 8'hFF);
        push_req(REQ_FIND, '0, 8'hFF);
        push_req(REQ_FIND, '0, 8'h80);
        push_req(REQ_FIND, '0, 8'h4D);
        push_req(REQ_COUNT, '0, 8'h00);
        push_req(REQ_COUNT, '0, 8'hFF);
        push_req(REQ_COUNT, '0, 8'h81);
        for (int k = 0; k < 7; k++)
            push_req(REQ_EXTRACT, '0, '0);
        wait_idle();

        // Random phases; each boundary also pauses the sender until drained.
        run_phase(16, 70, 60, 1'b1, 1'b1);
        run_phase(31, 70, 70, 1'b1, 1'b0);
        run_phase(3,  40, 50, 1'b0, 1'b0);
        run_phase(0,  30, 60, 1'b1, 1'b0);
        run_phase(1,  50, 50, 1'b1, 1'b0);
        run_phase(8,  70, 55, 1'b0, 1'b0);
        run_phase(17, 70, 65, 1'b1, 1'b0);
        run_phase(16, 60, 40, 1'b1, 1'b0);
        run_phase(5,  60, 50, 1'b1, 1'b0);

        repeat (DRAIN_WAIT) @(negedge aclk);
        if (n_err == 0 && rsp_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/apq_pkg.sv
rtl/apq_ctrl.sv
rtl/apq_datapath.sv
rtl/array_priority_queue_core.sv
tb/array_priority_queue_core_tb.sv
